/* sv/obc_pkg.sv */
// Shared constants, register indexes and the result record for the 2x2 opening check.
// No dependencies; imported by the line memory, the result queue and the top level.
`default_nettype none

package obc_pkg;

    localparam int DIM_W       = 7;
    localparam int MAX_DIM_DEF = 64;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int CNT_W       = 12;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 32;

    localparam logic [DIM_W-1:0]     DIM_RESET = 7'd64;
    localparam logic [CNT_W-1:0]     COUNT_MAX = 12'd4095;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 8'd1;

    typedef struct packed {
        logic             is_verdict;
        logic [ROW_W-1:0] square_row;
        logic [COL_W-1:0] square_col;
        logic             fill_ok;
        logic [CNT_W-1:0] square_count;
    } result_t;

endpackage

`default_nettype wire

/* sv/obc_line_mem.sv */
// Line memory: one entry per column, synchronous write, registered read.
// A write to the address being read in the same cycle is forwarded to the read data.
`default_nettype none

module obc_line_mem import obc_pkg::*; #(
    parameter int DEPTH  = MAX_DIM_DEF,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 8
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/obc_result_fifo.sv */
// Four-entry result queue taking up to two requests per cycle, one out per cycle while out_ready is high.
// Depends on obc_pkg for result_t.
`default_nettype none

module obc_result_fifo import obc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] push_cnt,
    input  wire result_t    push_item0,
    input  wire result_t    push_item1,
    output logic            space_ok,
    output logic            out_valid,
    output result_t         out_item,
    input  wire logic       out_ready
);

    localparam int DEPTH = 4;

    result_t    ent_reg [DEPTH];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = cnt_reg != 3'd0;
    assign out_item  = ent_reg[rp_reg];
    assign space_ok  = cnt_reg <= 3'd2;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wp_next  = wp_reg + push_cnt;
        rp_next  = pop ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            ent_reg[wp_reg] <= push_item0;
        end
        if (push_cnt == 2'd2) begin
            ent_reg[wp_reg + 2'd1] <= push_item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* sv/binary_image_2x2_opening_check_top.sv */
// Top level of the 2x2 opening check: scan control, config registers, line memory, result queue.
// Depends on obc_pkg, obc_line_mem and obc_result_fifo.
//
// The block takes one pixel per clock in row-major order and reports every all-ones 2x2
// square by its top-left corner, then a verdict (fill_ok, square_count) after the last
// pixel. Throughput is one pixel per cycle: the only per-column state lives in a line
// memory with one read and one write port, read one column ahead and written one column
// behind, so each pixel costs one read and one write. The last pixel of an image may issue
// two results; the four-entry result queue absorbs them, and s_tready drops only when
// the sink holds back m_tready. Image size comes from the rows/cols registers
// (0 acts as 1, values above MAX_DIM act as MAX_DIM). No clearing pass is needed after reset.
`default_nettype none

module binary_image_2x2_opening_check_top import obc_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [0] pixel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [5:0] square_row, [11:6] square_col,
                                                  // [12] fill_ok, [24:13] square_count
    output logic [0:0]                 m_tuser,   // [0] is_verdict
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int POS_W  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int FILL_W = POS_W + 1;
    localparam int CW     = (FILL_W > DIM_W) ? FILL_W : DIM_W;
    localparam int ENT_W  = POS_W + 2;

    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              unc_reg, unc_next;
    logic              left_reg, left_next;
    logic              ul_reg, ul_next;
    logic              cpm1_reg, cpm1_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]  pend_addr_reg;
    logic              pend_pix_reg;
    logic              pend_cov_reg;
    logic [POS_W-1:0]  pend_tag_reg;

    logic              accept;
    logic              pix;
    logic [CW-1:0]     rows_eff, cols_eff;
    logic              last_col, last_row, verdict;
    logic              r_nz, c_nz, ent_ok, pend_hit;
    logic [ENT_W-1:0]  rd_ent, use_ent;
    logic              up, cov_base, sq;
    logic              unc_a, unc_b, unc_c, unc_d;
    logic [FILL_W-1:0] col_plus1;

    logic              wr_en;
    logic [POS_W-1:0]  wr_addr, rd_addr;
    logic [ENT_W-1:0]  wr_data;

    logic [1:0]        push_cnt;
    result_t           sq_item, vd_item, push_item0, push_item1, out_item;
    logic              space_ok;

    assign cfg_ready = 1'b1;
    assign s_tready  = space_ok;
    assign accept    = s_tvalid && s_tready;
    assign pix       = s_tdata[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_ROWS: rows_reg <= cfg_data[DIM_W-1:0];
                CFG_IDX_COLS: cols_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (rows_reg == '0) begin
            rows_eff = CW'(1);
        end else if (CW'(rows_reg) > CW'(MAX_DIM)) begin
            rows_eff = CW'(MAX_DIM);
        end else begin
            rows_eff = CW'(rows_reg);
        end
        if (cols_reg == '0) begin
            cols_eff = CW'(1);
        end else if (CW'(cols_reg) > CW'(MAX_DIM)) begin
            cols_eff = CW'(MAX_DIM);
        end else begin
            cols_eff = CW'(cols_reg);
        end
    end

    always_comb begin
        last_col  = (CW'(col_reg) + CW'(1)) >= cols_eff;
        last_row  = (CW'(row_reg) + CW'(1)) >= rows_eff;
        verdict   = last_col && last_row;
        r_nz      = row_reg != '0;
        c_nz      = col_reg != '0;
        col_plus1 = FILL_W'(col_reg) + FILL_W'(1);

        pend_hit = pend_valid_reg && (pend_addr_reg == col_reg);
        use_ent  = pend_hit ? {pend_tag_reg, pend_cov_reg, pend_pix_reg} : rd_ent;
        ent_ok   = FILL_W'(col_reg) < fill_reg;
        up       = r_nz && ent_ok && use_ent[0];
        cov_base = r_nz && ent_ok && use_ent[1]
                   && (use_ent[ENT_W-1:2] == (row_reg - POS_W'(1)));
        sq       = r_nz && c_nz && pix && left_reg && up && ul_reg;

        unc_a = r_nz && c_nz && ul_reg && !(cpm1_reg || sq);
        unc_b = r_nz && last_col && up && !(cov_base || sq);
        unc_c = last_row && c_nz && left_reg && !(pend_cov_reg || sq);
        unc_d = last_row && last_col && pix && !sq;

        unc_next   = unc_reg || unc_a || unc_b || unc_c || unc_d;
        count_next = (sq && (count_reg != COUNT_MAX)) ? count_reg + CNT_W'(1) : count_reg;
        ul_next    = last_col ? 1'b0 : up;
        left_next  = last_col ? 1'b0 : pix;
        cpm1_next  = last_col ? 1'b0 : (cov_base || sq);
        col_next   = last_col ? '0 : col_reg + POS_W'(1);
        row_next   = last_col ? (last_row ? '0 : row_reg + POS_W'(1)) : row_reg;
        fill_next  = (fill_reg < col_plus1) ? col_plus1 : fill_reg;
        pend_valid_next = !verdict;

        wr_en   = accept && pend_valid_reg;
        wr_addr = pend_addr_reg;
        wr_data = {pend_tag_reg, pend_cov_reg || sq, pend_pix_reg};
        rd_addr = accept ? col_next : col_reg;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_addr_reg <= col_reg;
            pend_pix_reg  <= pix;
            pend_cov_reg  <= sq;
            pend_tag_reg  <= row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            col_reg        <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            unc_reg        <= 1'b0;
            left_reg       <= 1'b0;
            ul_reg         <= 1'b0;
            cpm1_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (accept) begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            ul_reg         <= ul_next;
            left_reg       <= left_next;
            cpm1_reg       <= cpm1_next;
            pend_valid_reg <= pend_valid_next;
            if (verdict) begin
                fill_reg  <= '0;
                count_reg <= '0;
                unc_reg   <= 1'b0;
            end else begin
                fill_reg  <= fill_next;
                count_reg <= count_next;
                unc_reg   <= unc_next;
            end
        end
    end

    obc_line_mem #(
        .DEPTH  (MAX_DIM),
        .ADDR_W (POS_W),
        .WIDTH  (ENT_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_ent)
    );

    always_comb begin
        sq_item.is_verdict   = 1'b0;
        sq_item.square_row   = ROW_W'(row_reg - POS_W'(1));
        sq_item.square_col   = COL_W'(col_reg - POS_W'(1));
        sq_item.fill_ok      = 1'b0;
        sq_item.square_count = '0;

        vd_item.is_verdict   = 1'b1;
        vd_item.square_row   = '0;
        vd_item.square_col   = '0;
        vd_item.fill_ok      = !unc_next;
        vd_item.square_count = count_next;

        push_item0 = sq ? sq_item : vd_item;
        push_item1 = vd_item;
        if (!accept) begin
            push_cnt = 2'd0;
        end else begin
            push_cnt = {1'b0, sq} + {1'b0, verdict};
        end
    end

    obc_result_fifo u_result_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push_item0 (push_item0),
        .push_item1 (push_item1),
        .space_ok   (space_ok),
        .out_valid  (m_tvalid),
        .out_item   (out_item),
        .out_ready  (m_tready)
    );

    assign m_tuser = out_item.is_verdict;
    assign m_tdata = {
        (OUT_DATA_W - ROW_W - COL_W - 1 - CNT_W)'(0),
        out_item.square_count,
        out_item.fill_ok,
        out_item.square_col,
        out_item.square_row
    };

endmodule

`default_nettype wire

/* test/obc_opening_checker.sv */
// Checker for the 2x2 opening check: follows the config, pixel and result channels, predicts
// square reports and verdicts from the accepted pixels and compares every accepted result.
// Depends on obc_pkg for widths, register indexes and result_t.
module obc_opening_checker import obc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [0:0]            m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 40;
    localparam int COL_LSB     = ROW_W;
    localparam int OK_BIT      = ROW_W + COL_W;
    localparam int CNT_LSB     = OK_BIT + 1;
    localparam int PAD_LSB     = CNT_LSB + CNT_W;

    logic [DIM_W-1:0]     rows_reg, cols_reg;
    bit [MAX_DIM_DEF-1:0] above_px, above_cov, row_cov;
    bit                   left_px, upleft_px, stray_one;
    int unsigned          row_pos, col_pos;
    logic [CNT_W-1:0]     square_total;
    result_t              expected_q[$];

    function automatic int unsigned usable_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return v;
    endfunction

    task automatic restart_image();
        above_px     = '0;
        above_cov    = '0;
        row_cov      = '0;
        left_px      = 1'b0;
        upleft_px    = 1'b0;
        stray_one    = 1'b0;
        row_pos      = 0;
        col_pos      = 0;
        square_total = '0;
    endtask

    task automatic scan_pixel(input bit px);
        int unsigned nrows, ncols, r, c;
        bit          last_c, last_r, up, ul;
        result_t     res;
        nrows  = usable_dim(rows_reg);
        ncols  = usable_dim(cols_reg);
        r      = row_pos;
        c      = col_pos;
        last_c = (c + 1) >= ncols;
        last_r = (r + 1) >= nrows;
        up     = above_px[c];
        ul     = upleft_px;
        if (r >= 1 && c >= 1 && px && left_px && up && ul) begin
            res            = '0;
            res.square_row = ROW_W'(r - 1);
            res.square_col = COL_W'(c - 1);
            expected_q.push_back(res);
            if (square_total != COUNT_MAX) square_total++;
            above_cov[c-1] = 1'b1;
            above_cov[c]   = 1'b1;
            row_cov[c-1]   = 1'b1;
            row_cov[c]     = 1'b1;
        end
        // flag ones that no later square can reach
        if (r >= 1 && c >= 1 && ul && !above_cov[c-1]) stray_one = 1'b1;
        if (r >= 1 && last_c && up && !above_cov[c]) stray_one = 1'b1;
        if (last_r && c >= 1 && left_px && !row_cov[c-1]) stray_one = 1'b1;
        if (last_r && last_c && px && !row_cov[c]) stray_one = 1'b1;
        upleft_px   = up;
        above_px[c] = px;
        left_px     = px;
        if (last_c) begin
            left_px   = 1'b0;
            upleft_px = 1'b0;
            above_cov = row_cov;
            row_cov   = '0;
            col_pos   = 0;
            if (last_r) begin
                res              = '0;
                res.is_verdict   = 1'b1;
                res.fill_ok      = !stray_one;
                res.square_count = square_total;
                expected_q.push_back(res);
                restart_image();
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result();
        result_t got, want;
        got.is_verdict   = m_tuser[0];
        got.square_row   = m_tdata[ROW_W-1:0];
        got.square_col   = m_tdata[OK_BIT-1:COL_LSB];
        got.fill_ok      = m_tdata[OK_BIT];
        got.square_count = m_tdata[PAD_LSB-1:CNT_LSB];
        results_checked++;
        if (m_tdata[OUT_DATA_W-1:PAD_LSB] != '0)
            report_mismatch("tdata padding", m_tdata[OUT_DATA_W-1:PAD_LSB], 0);
        if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending", got, 0);
        end else begin
            want = expected_q.pop_front();
            if (got.is_verdict != want.is_verdict)
                report_mismatch("is_verdict", got.is_verdict, want.is_verdict);
            if (got.square_row != want.square_row)
                report_mismatch("square_row", got.square_row, want.square_row);
            if (got.square_col != want.square_col)
                report_mismatch("square_col", got.square_col, want.square_col);
            if (got.fill_ok != want.fill_ok)
                report_mismatch("fill_ok", got.fill_ok, want.fill_ok);
            if (got.square_count != want.square_count)
                report_mismatch("square_count", got.square_count, want.square_count);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg = DIM_RESET;
            cols_reg = DIM_RESET;
            restart_image();
            expected_q.delete();
            mismatches      = 0;
            results_checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IDX_ROWS) rows_reg = cfg_data[DIM_W-1:0];
                else if (cfg_index == CFG_IDX_COLS) cols_reg = cfg_data[DIM_W-1:0];
            end
            if (s_tvalid && s_tready) scan_pixel(s_tdata[0]);
            if (m_tvalid && m_tready) check_result();
        end
        outstanding = expected_q.size();
    end

endmodule

/* test/tb_top.sv */
// Testbench top for the 2x2 opening check: clock, reset, pixel and register stimulus,
// output-side stalls and the final verdict.
// Depends on obc_pkg, binary_image_2x2_opening_check_top and obc_opening_checker.
module tb_top import obc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 8'hA5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 8'h5A;
    localparam int RANDOM_PIXELS    = 1050;
    localparam int SETTLE_CYCLES    = 16;
    localparam int SINK_HOLD_CYCLES = 200;

    typedef enum int {FILL_NOISE, FILL_SQUARES, FILL_STRAY, FILL_SOLID, FILL_BROKEN} fill_kind_t;
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_CYCLIC} sink_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [0] pixel
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [5:0] square_row, [11:6] square_col,
                                      // [12] fill_ok, [24:13] square_count
    logic [0:0]            m_tuser;   // [0] is_verdict
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches, outstanding, results_checked;
    int burst_left, pixels_sent, cur_rows, cur_cols;
    bit hold_req;
    bit [MAX_DIM_DEF-1:0] picture [MAX_DIM_DEF];

    binary_image_2x2_opening_check_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    obc_opening_checker opening_watch (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int usable_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_pixel(input bit px);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = IN_DATA_W'(px);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stop_sending();
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == CFG_IDX_ROWS) cur_rows = usable_dim(val[DIM_W-1:0]);
        else if (idx == CFG_IDX_COLS) cur_cols = usable_dim(val[DIM_W-1:0]);
    endtask

    task automatic set_dims(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols);
        write_reg(CFG_IDX_ROWS, rows);
        write_reg(CFG_IDX_COLS, cols);
    endtask

    // output side: random stall patterns, plus one long hold on request
    initial begin
        sink_mode_t mode;
        int         mode_left, phase;
        m_tready  = 1'b0;
        mode      = SINK_OPEN;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                phase++;
                case (mode)
                    SINK_OPEN:   m_tready = 1'b1;
                    SINK_COIN:   m_tready = 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                    default:     m_tready = (phase % 8) < 3;
                endcase
            end
        end
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        fill_kind_t kind;
        int idx, rand_start, roll, density, r, c, k, total, cut, resizes;
        int rows_pick, cols_pick;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 1'b0;
        burst_left  = 0;
        pixels_sent = 0;
        resizes     = 0;
        cur_rows    = MAX_DIM_DEF;
        cur_cols    = MAX_DIM_DEF;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // full square, broken square, empty image
        set_dims(8'd2, 8'd2);
        repeat (4) send_pixel(1'b1);
        repeat (3) send_pixel(1'b1);
        send_pixel(1'b0);
        repeat (4) send_pixel(1'b0);
        // zero rows and zero columns act as one
        set_dims(8'd0, 8'd2);
        send_pixel(1'b1);
        send_pixel(1'b0);
        write_reg(CFG_IDX_COLS, 8'd0);
        send_pixel(1'b0);
        send_pixel(1'b1);
        // overlapping squares
        set_dims(8'd3, 8'd3);
        repeat (9) send_pixel(1'b1);
        write_reg(CFG_IDX_SPARE_A, 8'h55);
        write_reg(CFG_IDX_SPARE_B, 8'hAA);

        rand_start = pixels_sent;
        idx = 0;
        while (pixels_sent - rand_start < RANDOM_PIXELS) begin
            case (idx)
                0: set_dims(8'd127, 8'd2);
                1: set_dims(8'd64, 8'd1);
                2: begin
                    set_dims(8'd2, 8'd200);
                    hold_req = 1'b1;
                end
                3: set_dims(8'd2, 8'd0);
                default: if (idx == 4 || $urandom_range(0, 99) < 35) begin
                    rows_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                            : $urandom_range(2, 8);
                    cols_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                            : $urandom_range(2, 8);
                    set_dims(CFG_DATA_W'(rows_pick), CFG_DATA_W'(cols_pick));
                end
            endcase

            roll = $urandom_range(0, 99);
            kind = (idx == 2 || (roll >= 70 && roll < 80)) ? FILL_SOLID :
                   (roll < 25) ? FILL_NOISE :
                   (roll < 55) ? FILL_SQUARES :
                   (roll < 70) ? FILL_STRAY : FILL_BROKEN;
            density = $urandom_range(0, 100);
            for (r = 0; r < MAX_DIM_DEF; r++) picture[r] = '0;
            for (r = 0; r < cur_rows; r++)
                for (c = 0; c < cur_cols; c++)
                    picture[r][c] = (kind == FILL_SOLID) ||
                                    (kind == FILL_NOISE && $urandom_range(0, 99) < density);
            if (kind != FILL_NOISE && kind != FILL_SOLID && cur_rows > 1 && cur_cols > 1) begin
                repeat ($urandom_range(1, cur_rows * cur_cols / 4 + 1)) begin
                    r = $urandom_range(0, cur_rows - 2);
                    c = $urandom_range(0, cur_cols - 2);
                    picture[r][c]     = 1'b1;
                    picture[r][c+1]   = 1'b1;
                    picture[r+1][c]   = 1'b1;
                    picture[r+1][c+1] = 1'b1;
                end
            end
            r = $urandom_range(0, cur_rows - 1);
            c = $urandom_range(0, cur_cols - 1);
            if (kind == FILL_STRAY) picture[r][c] = 1'b1;
            if (kind == FILL_BROKEN) picture[r][c] = 1'b0;

            total = cur_rows * cur_cols;
            cut = ((idx == 6 || idx == 11 || $urandom_range(0, 99) < 5) && total >= 2)
                  ? $urandom_range(1, total - 1) : total;
            for (k = 0; k < cut; k++) send_pixel(picture[k / cur_cols][k % cur_cols]);
            if (cut < total) begin
                // resize mid-image, then finish it with noise
                resizes++;
                r = cut / cur_cols;
                c = cut % cur_cols;
                if ($urandom_range(0, 1)) write_reg(CFG_IDX_COLS, CFG_DATA_W'($urandom_range(0, 8)));
                else write_reg(CFG_IDX_ROWS, CFG_DATA_W'($urandom_range(0, 8)));
                while (1) begin
                    send_pixel(1'($urandom_range(0, 1)));
                    if (c + 1 >= cur_cols) begin
                        if (r + 1 >= cur_rows) break;
                        r++;
                        c = 0;
                    end else begin
                        c++;
                    end
                end
            end
            idx++;
        end

        stop_sending();
        wait (outstanding == 0);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        $display("Checked %0d results from %0d pixels in %0d random images, up to 64 rows or columns",
                 results_checked, pixels_sent, idx);
        $display("with out-of-range size registers, %0d mid-image resizes and a long output stall",
                 resizes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
